[rtl/core/ecgmab_pkg.sv]
// shared types and constants of the ecg moving-average band-pass filter
`timescale 1ns / 1ps

package ecgmab_pkg;

    // configuration port layout
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // register indexes
    localparam cfg_index_t REG_HP_WINDOW = 2'd0;
    localparam cfg_index_t REG_LP_WINDOW = 2'd1;

    // register widths and reset values
    localparam int HP_WINDOW_CFG_W = 9;
    localparam int LP_WINDOW_CFG_W = 7;
    localparam int HP_WINDOW_RESET = 216;
    localparam int LP_WINDOW_RESET = 43;

    // item sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HP_SUM,
        ST_HP_LOAD,
        ST_HP_DIV,
        ST_HP_END,
        ST_LP_SUM,
        ST_LP_LOAD,
        ST_LP_DIV,
        ST_LP_END
    } state_t;

endpackage

[rtl/core/ecgmab_serdiv.sv]
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ecgmab_serdiv #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 9,
    parameter int QUOT_W     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,   // quotient must fit in QUOT_W bits
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  last,       // final step happens at this edge
    output logic [QUOT_W-1:0]     quotient
);

    localparam int HIGH_W = DIVIDEND_W - QUOT_W;
    localparam int REM_W  = ((HIGH_W > DIVISOR_W) ? HIGH_W : DIVISOR_W) + 1;
    localparam int CNT_W  = $clog2(QUOT_W + 1);

    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [QUOT_W-1:0]    dq_reg;
    logic [QUOT_W-1:0]    dq_next;
    logic [DIVISOR_W-1:0] div_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic [REM_W-1:0]     trial;
    logic [REM_W:0]       diff;
    logic                 fits;

    // shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg[REM_W-2:0], dq_reg[QUOT_W-1]};
    assign diff  = {1'b0, trial} - (REM_W+1)'(div_reg);
    assign fits  = ~diff[REM_W];

    always_comb
    begin
        if (start)
        begin
            rem_next = REM_W'(dividend[DIVIDEND_W-1:QUOT_W]);
            dq_next  = dividend[QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[REM_W-1:0] : trial;
            dq_next  = {dq_reg[QUOT_W-2:0], fits};
        end
        else
        begin
            rem_next = rem_reg;
            dq_next  = dq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign last     = busy_reg && (cnt_reg == CNT_W'(1));
    assign quotient = dq_reg;

endmodule

[rtl/core/ecg_moving_average_bandpass.sv]
// ecg band-pass filter built from two moving averages with serial division
//
// usage
//   s_axis carries one signed ecg sample per item; m_axis returns one
//   band-passed sample per item, in order. cfg writes a window length:
//   index 0 is the high-pass window, index 1 the low-pass window. a write
//   restarts that stage (sum, pointer and fill count back to zero). a window
//   of zero acts as one, a window above the stage maximum acts as the maximum.
//   write configuration only while no item is in flight.
// sequence
//   an item goes from acceptance to m_axis_tvalid through, per stage, a sum
//   update and history write, a divider load, a bit-serial division of
//   SAMPLE_BITS steps on the shared divider and a quotient pickup.
//   s_axis_tready is high only in the idle state, which is entered once the
//   result is loaded, so the next item is accepted only after the current
//   one is done.
// stall
//   the result sits in an output register; the next item is accepted and
//   computed while it waits, and holds in its final step until m_axis_tready.
// reset
//   sums, pointers and fill counts clear and the windows return to 216 and
//   43; the history memories are not cleared; their reads count only once full.
`timescale 1ns / 1ps

module ecg_moving_average_bandpass #(
    parameter int HP_MAX_WINDOW = 256,
    parameter int LP_MAX_WINDOW = 64,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // sample
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+8)/8)*8-1:0]      m_axis_tdata,   // band_sample
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  ecgmab_pkg::cfg_index_t                cfg_index,
    input  logic [ecgmab_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SB       = SAMPLE_BITS;
    localparam int OUT_W    = ((SAMPLE_BITS + 8) / 8) * 8;
    localparam int HP_PTR_W = $clog2(HP_MAX_WINDOW);
    localparam int HP_WIN_W = $clog2(HP_MAX_WINDOW + 1);
    localparam int HP_SUM_W = SB + $clog2(HP_MAX_WINDOW);
    localparam int LP_PTR_W = $clog2(LP_MAX_WINDOW);
    localparam int LP_WIN_W = $clog2(LP_MAX_WINDOW + 1);
    localparam int LP_SUM_W = SB + 1 + $clog2(LP_MAX_WINDOW);
    localparam int MAG_W    = (HP_SUM_W > LP_SUM_W) ? HP_SUM_W : LP_SUM_W;
    localparam int CNT_W    = (HP_WIN_W > LP_WIN_W) ? HP_WIN_W : LP_WIN_W;
    localparam int HP_WIN_RST = (ecgmab_pkg::HP_WINDOW_RESET > HP_MAX_WINDOW) ?
                                HP_MAX_WINDOW : ecgmab_pkg::HP_WINDOW_RESET;
    localparam int LP_WIN_RST = (ecgmab_pkg::LP_WINDOW_RESET > LP_MAX_WINDOW) ?
                                LP_MAX_WINDOW : ecgmab_pkg::LP_WINDOW_RESET;

    ecgmab_pkg::state_t state_reg;
    ecgmab_pkg::state_t state_next;

    // window registers hold the clamped length
    logic [HP_WIN_W-1:0]        hp_win_reg;
    logic [LP_WIN_W-1:0]        lp_win_reg;
    logic [HP_WIN_W-1:0]        hp_win_new;
    logic [LP_WIN_W-1:0]        lp_win_new;
    logic [ecgmab_pkg::HP_WINDOW_CFG_W-1:0] hp_win_raw;
    logic [ecgmab_pkg::LP_WINDOW_CFG_W-1:0] lp_win_raw;
    logic                       cfg_hp_wr;
    logic                       cfg_lp_wr;

    // high-pass stage
    logic signed [HP_SUM_W-1:0] hp_sum_reg;
    logic signed [HP_SUM_W-1:0] hp_sum_next;
    logic [HP_PTR_W-1:0]        hp_ptr_reg;
    logic [HP_PTR_W-1:0]        hp_ptr_inc;
    logic [HP_PTR_W-1:0]        hp_old_addr;
    logic [HP_WIN_W-1:0]        hp_seen_reg;
    logic [HP_WIN_W-1:0]        hp_cnt_reg;
    logic                       hp_full;
    logic signed [SB-1:0]       hp_mem [HP_MAX_WINDOW];
    logic signed [SB-1:0]       hp_rd_reg;

    // low-pass stage
    logic signed [LP_SUM_W-1:0] lp_sum_reg;
    logic signed [LP_SUM_W-1:0] lp_sum_next;
    logic [LP_PTR_W-1:0]        lp_ptr_reg;
    logic [LP_PTR_W-1:0]        lp_ptr_inc;
    logic [LP_PTR_W-1:0]        lp_old_addr;
    logic [LP_WIN_W-1:0]        lp_seen_reg;
    logic [LP_WIN_W-1:0]        lp_cnt_reg;
    logic                       lp_full;
    logic signed [SB:0]         lp_mem [LP_MAX_WINDOW];
    logic signed [SB:0]         lp_rd_reg;

    // datapath between stages
    logic signed [SB-1:0]       x_reg;
    logic signed [SB:0]         y_reg;
    logic                       neg_reg;
    logic signed [SB:0]         mean_signed;
    logic [HP_SUM_W-1:0]        hp_abs;
    logic [LP_SUM_W-1:0]        lp_abs;
    logic [MAG_W-1:0]           div_dividend;
    logic [CNT_W-1:0]           div_divisor;
    logic [SB-1:0]              div_quot;
    logic                       div_last;

    // output register
    logic                       m_valid_reg;
    logic signed [SB:0]         m_data_reg;

    // sequencer outputs
    logic                       hp_rd_en;
    logic                       hp_wr_en;
    logic                       lp_rd_en;
    logic                       lp_wr_en;
    logic                       div_start;
    logic                       out_load;

    // ------------------------------------------------------------------
    // configuration decode and window clamp
    // ------------------------------------------------------------------
    assign cfg_ready  = 1'b1;
    assign hp_win_raw = cfg_data[ecgmab_pkg::HP_WINDOW_CFG_W-1:0];
    assign lp_win_raw = cfg_data[ecgmab_pkg::LP_WINDOW_CFG_W-1:0];

    always_comb
    begin
        cfg_hp_wr = 1'b0;
        cfg_lp_wr = 1'b0;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ecgmab_pkg::REG_HP_WINDOW: cfg_hp_wr = 1'b1;
                ecgmab_pkg::REG_LP_WINDOW: cfg_lp_wr = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (hp_win_raw == '0)
        begin
            hp_win_new = HP_WIN_W'(1);
        end
        else if (32'(hp_win_raw) > 32'(HP_MAX_WINDOW))
        begin
            hp_win_new = HP_WIN_W'(HP_MAX_WINDOW);
        end
        else
        begin
            hp_win_new = HP_WIN_W'(hp_win_raw);
        end

        if (lp_win_raw == '0)
        begin
            lp_win_new = LP_WIN_W'(1);
        end
        else if (32'(lp_win_raw) > 32'(LP_MAX_WINDOW))
        begin
            lp_win_new = LP_WIN_W'(LP_MAX_WINDOW);
        end
        else
        begin
            lp_win_new = LP_WIN_W'(lp_win_raw);
        end
    end

    // ------------------------------------------------------------------
    // ring addressing: the oldest entry sits one window behind the pointer
    // ------------------------------------------------------------------
    always_comb
    begin
        int hp_tmp;
        int lp_tmp;
        hp_tmp = int'(hp_ptr_reg) - int'(hp_win_reg);
        if (hp_tmp < 0)
        begin
            hp_tmp = hp_tmp + HP_MAX_WINDOW;
        end
        lp_tmp = int'(lp_ptr_reg) - int'(lp_win_reg);
        if (lp_tmp < 0)
        begin
            lp_tmp = lp_tmp + LP_MAX_WINDOW;
        end
        hp_old_addr = HP_PTR_W'(hp_tmp);
        lp_old_addr = LP_PTR_W'(lp_tmp);
    end

    assign hp_ptr_inc = (32'(hp_ptr_reg) == 32'(HP_MAX_WINDOW - 1)) ? '0 : hp_ptr_reg + 1'b1;
    assign lp_ptr_inc = (32'(lp_ptr_reg) == 32'(LP_MAX_WINDOW - 1)) ? '0 : lp_ptr_reg + 1'b1;
    assign hp_full    = hp_seen_reg >= hp_win_reg;
    assign lp_full    = lp_seen_reg >= lp_win_reg;

    // add the new value, drop the one leaving the window once full
    assign hp_sum_next = hp_sum_reg + HP_SUM_W'(x_reg)
                         - (hp_full ? HP_SUM_W'(hp_rd_reg) : HP_SUM_W'(0));
    assign lp_sum_next = lp_sum_reg + LP_SUM_W'(y_reg)
                         - (lp_full ? LP_SUM_W'(lp_rd_reg) : LP_SUM_W'(0));

    // ------------------------------------------------------------------
    // history memories, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (hp_wr_en)
        begin
            hp_mem[hp_ptr_reg] <= x_reg;
        end
        if (hp_rd_en)
        begin
            hp_rd_reg <= hp_mem[hp_old_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lp_wr_en)
        begin
            lp_mem[lp_ptr_reg] <= y_reg;
        end
        if (lp_rd_en)
        begin
            lp_rd_reg <= lp_mem[lp_old_addr];
        end
    end

    // ------------------------------------------------------------------
    // shared serial divider: |sum| / count, sign applied afterwards
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [HP_SUM_W-1:0] hp_neg;
        logic [LP_SUM_W-1:0] lp_neg;
        hp_neg = $unsigned(-hp_sum_reg);
        lp_neg = $unsigned(-lp_sum_reg);
        hp_abs = hp_sum_reg[HP_SUM_W-1] ? hp_neg : $unsigned(hp_sum_reg);
        lp_abs = lp_sum_reg[LP_SUM_W-1] ? lp_neg : $unsigned(lp_sum_reg);
    end

    assign div_dividend = (state_reg == ecgmab_pkg::ST_LP_LOAD) ? MAG_W'(lp_abs)
                                                                 : MAG_W'(hp_abs);
    assign div_divisor  = (state_reg == ecgmab_pkg::ST_LP_LOAD) ? CNT_W'(lp_cnt_reg)
                                                                 : CNT_W'(hp_cnt_reg);

    ecgmab_serdiv #(
        .DIVIDEND_W (MAG_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (SB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .last     (div_last),
        .quotient (div_quot)
    );

    assign mean_signed = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ecgmab_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ecgmab_pkg::ST_HP_SUM;
                end
            end
            ecgmab_pkg::ST_HP_SUM:  state_next = ecgmab_pkg::ST_HP_LOAD;
            ecgmab_pkg::ST_HP_LOAD: state_next = ecgmab_pkg::ST_HP_DIV;
            ecgmab_pkg::ST_HP_DIV:
            begin
                if (div_last)
                begin
                    state_next = ecgmab_pkg::ST_HP_END;
                end
            end
            ecgmab_pkg::ST_HP_END:  state_next = ecgmab_pkg::ST_LP_SUM;
            ecgmab_pkg::ST_LP_SUM:  state_next = ecgmab_pkg::ST_LP_LOAD;
            ecgmab_pkg::ST_LP_LOAD: state_next = ecgmab_pkg::ST_LP_DIV;
            ecgmab_pkg::ST_LP_DIV:
            begin
                if (div_last)
                begin
                    state_next = ecgmab_pkg::ST_LP_END;
                end
            end
            ecgmab_pkg::ST_LP_END:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ecgmab_pkg::ST_IDLE;
                end
            end
            default: state_next = ecgmab_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        hp_rd_en      = 1'b0;
        hp_wr_en      = 1'b0;
        lp_rd_en      = 1'b0;
        lp_wr_en      = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ecgmab_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                hp_rd_en      = 1'b1;
            end
            ecgmab_pkg::ST_HP_SUM:  hp_wr_en  = 1'b1;
            ecgmab_pkg::ST_HP_LOAD: div_start = 1'b1;
            ecgmab_pkg::ST_HP_DIV:  ;
            ecgmab_pkg::ST_HP_END:  lp_rd_en  = 1'b1;
            ecgmab_pkg::ST_LP_SUM:  lp_wr_en  = 1'b1;
            ecgmab_pkg::ST_LP_LOAD: div_start = 1'b1;
            ecgmab_pkg::ST_LP_DIV:  ;
            ecgmab_pkg::ST_LP_END:  out_load  = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // control and stage state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ecgmab_pkg::ST_IDLE;
            hp_win_reg  <= HP_WIN_W'(HP_WIN_RST);
            lp_win_reg  <= LP_WIN_W'(LP_WIN_RST);
            hp_sum_reg  <= '0;
            hp_ptr_reg  <= '0;
            hp_seen_reg <= '0;
            lp_sum_reg  <= '0;
            lp_ptr_reg  <= '0;
            lp_seen_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_hp_wr)
            begin
                hp_win_reg  <= hp_win_new;
                hp_sum_reg  <= '0;
                hp_ptr_reg  <= '0;
                hp_seen_reg <= '0;
            end
            else if (hp_wr_en)
            begin
                hp_sum_reg <= hp_sum_next;
                hp_ptr_reg <= hp_ptr_inc;
                if (32'(hp_seen_reg) < 32'(HP_MAX_WINDOW))
                begin
                    hp_seen_reg <= hp_seen_reg + 1'b1;
                end
            end

            if (cfg_lp_wr)
            begin
                lp_win_reg  <= lp_win_new;
                lp_sum_reg  <= '0;
                lp_ptr_reg  <= '0;
                lp_seen_reg <= '0;
            end
            else if (lp_wr_en)
            begin
                lp_sum_reg <= lp_sum_next;
                lp_ptr_reg <= lp_ptr_inc;
                if (32'(lp_seen_reg) < 32'(LP_MAX_WINDOW))
                begin
                    lp_seen_reg <= lp_seen_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            x_reg <= $signed(s_axis_tdata[SB-1:0]);
        end
        // divide by the count seen so far until the window is full
        if (hp_wr_en)
        begin
            hp_cnt_reg <= hp_full ? hp_win_reg : hp_seen_reg + 1'b1;
        end
        if (lp_wr_en)
        begin
            lp_cnt_reg <= lp_full ? lp_win_reg : lp_seen_reg + 1'b1;
        end
        if (state_reg == ecgmab_pkg::ST_HP_LOAD)
        begin
            neg_reg <= hp_sum_reg[HP_SUM_W-1];
        end
        else if (state_reg == ecgmab_pkg::ST_LP_LOAD)
        begin
            neg_reg <= lp_sum_reg[LP_SUM_W-1];
        end
        if (state_reg == ecgmab_pkg::ST_HP_END)
        begin
            y_reg <= (SB+1)'(x_reg) - mean_signed;
        end
        if (out_load)
        begin
            m_data_reg <= mean_signed;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'($unsigned(m_data_reg));

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hp_seen_reg) <= 32'(HP_MAX_WINDOW) && 32'(lp_seen_reg) <= 32'(LP_MAX_WINDOW))
        else $error("fill count beyond stage capacity");

    a_hp_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ecgmab_pkg::ST_HP_LOAD |-> hp_cnt_reg != '0 && hp_cnt_reg <= hp_win_reg)
        else $error("high-pass divisor outside one to window");

    a_div_last_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_last |-> state_reg == ecgmab_pkg::ST_HP_DIV || state_reg == ecgmab_pkg::ST_LP_DIV)
        else $error("divider finished outside a divide state");

    a_hp_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ecgmab_pkg::ST_HP_END |-> div_quot <= {1'b1, {(SB-1){1'b0}}})
        else $error("high-pass mean exceeds sample range");

endmodule

[verif/tb_ecg_moving_average_bandpass.sv]
// testbench of the ecg moving-average band-pass filter, self-checking against its own predictor
`timescale 1ns / 1ps

// method
//   a directed table walks the window extremes, the zero and oversize
//   windows, writes to unused indexes and full-scale samples. a long run of
//   random phases follows; each phase waits for the block to drain, rewrites
//   some windows and sends an ecg-like, extreme, flat or random sample run.
//   every accepted item is run through a behavioral copy of both averaging
//   stages and the band_sample it should produce is queued. every m_axis
//   item is checked against the oldest entry of that queue.
// item flow
//   the block accepts the next item only when the current one is done, so
//   the end of the run waits for the queue to empty and then for a margin
// idling
//   both sides idle in random bursts; the last items of the run go through
//   with neither side idling

module tb_ecg_moving_average_bandpass;

    localparam int HP_DEPTH    = 256;
    localparam int LP_DEPTH    = 64;
    localparam int ITEM_CYCLES = 7 + 2 * 16;
    localparam int RANDOM_ITEMS = 1930;
    localparam int QUIET_ITEMS  = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    // indexes that hold no register
    localparam ecgmab_pkg::cfg_index_t REG_UNUSED_A = 2'd2;
    localparam ecgmab_pkg::cfg_index_t REG_UNUSED_B = 2'd3;

    // one row of the directed table: either a sample or a register write
    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        ecgmab_pkg::cfg_index_t reg_idx;
        logic [15:0]            data;       // sample bits, or register data in the low 9
        logic                   known;      // band below is typed in
        logic signed [16:0]     band;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 30;

    logic clk;
    logic rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // sample[15:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // band_sample[16:0], zero fill [23:17]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    ecgmab_pkg::cfg_index_t cfg_index = ecgmab_pkg::REG_HP_WINDOW;
    logic [8:0]  cfg_data  = '0;

    ecg_moving_average_bandpass #(
        .HP_MAX_WINDOW (HP_DEPTH),
        .LP_MAX_WINDOW (LP_DEPTH),
        .SAMPLE_BITS   (16)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // predictor state, stage 0 is the high-pass stage, stage 1 the low-pass
    longint      stage_hist  [0:1][HP_DEPTH];
    longint      stage_total [0:1];
    int unsigned stage_wr    [0:1];
    int unsigned stage_fill  [0:1];
    int unsigned stage_win   [0:1];     // window register as written

    logic signed [16:0] band_expected [$];
    int  mismatch_count = 0;
    int  samples_sent   = 0;
    int  cycle_count    = 0;
    bit  quiet          = 1'b0;         // no idling on either side
    int  ready_hold     = 0;

    function automatic void restart_stage(input ecgmab_pkg::cfg_index_t s);
        stage_total[s] = 0;
        stage_wr[s]    = 0;
        stage_fill[s]  = 0;
    endfunction

    // one moving-average stage: running sum, circular history, partial
    // window after a restart, mean truncated toward zero
    function automatic longint stage_mean(input ecgmab_pkg::cfg_index_t s, input longint v);
        int unsigned cap;
        int unsigned win;
        int unsigned cnt;
        cap = (s == ecgmab_pkg::REG_LP_WINDOW) ? LP_DEPTH : HP_DEPTH;
        win = stage_win[s];
        if (win == 0)
            win = 1;
        else if (win > cap)
            win = cap;
        stage_total[s] += v;
        // drop the value that leaves the window once it is full
        if (stage_fill[s] >= win)
            stage_total[s] -= stage_hist[s][(stage_wr[s] + cap - win) % cap];
        stage_hist[s][stage_wr[s]] = v;
        stage_wr[s] = (stage_wr[s] + 1) % cap;
        cnt = (stage_fill[s] + 1 > win) ? win : stage_fill[s] + 1;
        if (stage_fill[s] < cap)
            stage_fill[s]++;
        return stage_total[s] / longint'(cnt);
    endfunction

    // high-pass: sample minus its mean; low-pass: mean of those differences
    function automatic logic signed [16:0] predict_band(input logic [15:0] raw);
        longint x;
        longint y;
        x = longint'($signed(raw));
        y = x - stage_mean(ecgmab_pkg::REG_HP_WINDOW, x);
        return 17'(stage_mean(ecgmab_pkg::REG_LP_WINDOW, y));
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // leaves valid high so a following item is offered without a drop in valid
    task automatic send_sample(input logic [15:0] raw, input logic known,
                               input logic signed [16:0] typed);
        logic signed [16:0] band;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        do
            @(posedge clk);
        while (!s_axis_tready);
        band = predict_band(raw);
        band_expected.insert(band_expected.size(), known ? typed : band);
        samples_sent++;
    endtask

    // leaves cfg_valid high; the caller lowers it after its last write
    task automatic write_register(input ecgmab_pkg::cfg_index_t idx, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            ecgmab_pkg::REG_HP_WINDOW:
            begin
                stage_win[ecgmab_pkg::REG_HP_WINDOW] = value;
                restart_stage(ecgmab_pkg::REG_HP_WINDOW);
            end
            ecgmab_pkg::REG_LP_WINDOW:
            begin
                stage_win[ecgmab_pkg::REG_LP_WINDOW] = value[6:0];
                restart_stage(ecgmab_pkg::REG_LP_WINDOW);
            end
            default: ;  // no register there, nothing changes
        endcase
    endtask

    // stop sending and hold off until every queued result is back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (band_expected.size() != 0)
            @(posedge clk);
    endtask

    // random sender idling, odds out of 8 per item
    task automatic sender_gap(input int odds);
        if (!quiet && odds != 0 && $urandom_range(0, 7) < odds)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // directed table: after reset, zero and oversize windows, unused
    // indexes, a short window with full-scale swings, the largest windows
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // first sample after reset equals its own mean
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h7FFF, 1'b1, 17'sd0},
        // hp mean (32767 - 32768) / 2 truncates to 0, lp mean of 0 and -32768
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b1, -17'sd16384},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h0000, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h0001, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'hFFFF, 1'b0, 17'sd0},
        // zero windows act as one, so the high-pass output is always zero
        '{ROW_WRITE,  ecgmab_pkg::REG_HP_WINDOW, 16'h0000, 1'b0, 17'sd0},
        '{ROW_WRITE,  ecgmab_pkg::REG_LP_WINDOW, 16'h0000, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h7FFF, 1'b1, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b1, 17'sd0},
        // all ones saturates hp to 256; lp keeps 7 bits and saturates to 64
        '{ROW_WRITE,  ecgmab_pkg::REG_HP_WINDOW, 16'h01FF, 1'b0, 17'sd0},
        '{ROW_WRITE,  ecgmab_pkg::REG_LP_WINDOW, 16'h01FF, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b1, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h7FFF, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h3039, 1'b0, 17'sd0},
        // unused indexes must neither change a window nor restart a stage
        '{ROW_WRITE,  REG_UNUSED_A,              16'h0155, 1'b0, 17'sd0},
        '{ROW_WRITE,  REG_UNUSED_B,              16'h00AA, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b0, 17'sd0},
        // short hp window filled at the negative rail, then a positive step
        '{ROW_WRITE,  ecgmab_pkg::REG_HP_WINDOW, 16'h0004, 1'b0, 17'sd0},
        '{ROW_WRITE,  ecgmab_pkg::REG_LP_WINDOW, 16'h0001, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b1, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h7FFF, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h7FFF, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h7FFF, 1'b0, 17'sd0},
        // largest legal windows
        '{ROW_WRITE,  ecgmab_pkg::REG_HP_WINDOW, 16'h0100, 1'b0, 17'sd0},
        '{ROW_WRITE,  ecgmab_pkg::REG_LP_WINDOW, 16'h0040, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'hFFFF, 1'b0, 17'sd0},
        '{ROW_SAMPLE, ecgmab_pkg::REG_HP_WINDOW, 16'h8000, 1'b0, 17'sd0}
    };

    // result checker, sampled at the edge where the handshake happens
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (band_expected.size() == 0)
                report_mismatch($sformatf("band_sample %0d with no item outstanding",
                                          $signed(m_axis_tdata[16:0])));
            else
            begin
                if (m_axis_tdata[16:0] !== band_expected[0])
                    report_mismatch($sformatf("band_sample %0d, expected %0d",
                                              $signed(m_axis_tdata[16:0]),
                                              band_expected[0]));
                if (m_axis_tdata[23:17] !== 7'd0)
                    report_mismatch($sformatf("tdata fill bits 0x%0h, expected zero",
                                              m_axis_tdata[23:17]));
                void'(band_expected.pop_front());
            end
        end
    end

    // receiver: random stalls between ready stretches, some stretches long
    always @(posedge clk)
    begin
        if (quiet)
        begin
            m_axis_tready <= 1'b1;
            ready_hold    <= 0;
        end
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (m_axis_tready)
        begin
            m_axis_tready <= 1'b0;
            ready_hold    <= $urandom_range(0, 16);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            ready_hold    <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(0, 40);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] x;
        logic [8:0]  value;
        bit          writing;
        int          phase_len;
        int          pattern;
        int          gap_odds;
        int          level;
        int          v;
        int          sent_random;

        writing     = 1'b0;
        level       = 0;
        sent_random = 0;

        // predictor starts from the reset windows
        stage_win[ecgmab_pkg::REG_HP_WINDOW] = ecgmab_pkg::HP_WINDOW_RESET;
        stage_win[ecgmab_pkg::REG_LP_WINDOW] = ecgmab_pkg::LP_WINDOW_RESET;
        restart_stage(ecgmab_pkg::REG_HP_WINDOW);
        restart_stage(ecgmab_pkg::REG_LP_WINDOW);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; writes go out only once the block is empty
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                if (!writing)
                    drain();
                write_register(directed_rows[r].reg_idx, directed_rows[r].data[8:0]);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                begin
                    cfg_valid <= 1'b0;
                    writing = 1'b0;
                end
                else
                    sender_gap(2);
                send_sample(directed_rows[r].data, directed_rows[r].known,
                            directed_rows[r].band);
            end
        end

        // random phases: drain, rewrite some windows, then a run of samples
        while (sent_random < RANDOM_ITEMS)
        begin
            drain();
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       value = 9'd0;
                    1:       value = 9'd1;
                    2:       value = 9'd256;
                    3:       value = 9'($urandom_range(257, 511));
                    4:       value = 9'($urandom_range(1, 256));
                    default: value = 9'($urandom_range(2, 40));
                endcase
                write_register(ecgmab_pkg::REG_HP_WINDOW, value);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       value = 9'd0;
                    1:       value = 9'd1;
                    2:       value = 9'd64;
                    3:       value = 9'($urandom_range(65, 511));
                    4:       value = 9'($urandom_range(1, 64));
                    default: value = 9'($urandom_range(2, 20));
                endcase
                write_register(ecgmab_pkg::REG_LP_WINDOW, value);
            end
            if ($urandom_range(0, 7) == 0)
                write_register($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B,
                               9'($urandom));
            cfg_valid <= 1'b0;

            phase_len = $urandom_range(20, 220);
            pattern   = $urandom_range(0, 4);
            gap_odds  = $urandom_range(0, 3);
            v         = $urandom_range(0, 65535) - 32768;
            for (int i = 0; i < phase_len && sent_random < RANDOM_ITEMS; i++)
            begin
                case ((pattern == 4) ? $urandom_range(0, 3) : pattern)
                    0: x = 16'($urandom);
                    1:
                    begin
                        // rails and the values next to zero
                        case ($urandom_range(0, 4))
                            0:       x = 16'h7FFF;
                            1:       x = 16'h8000;
                            2:       x = 16'h0000;
                            3:       x = 16'hFFFF;
                            default: x = 16'($urandom);
                        endcase
                    end
                    2:
                    begin
                        // wandering baseline, small noise, an r-wave now and then
                        level += int'($urandom_range(0, 100)) - 50;
                        if (level > 10000)
                            level = 10000;
                        else if (level < -10000)
                            level = -10000;
                        v = level + int'($urandom_range(0, 200)) - 100;
                        if ($urandom_range(0, 39) == 0)
                            v = level + 20000 + int'($urandom_range(0, 12767));
                        if (v > 32767)
                            v = 32767;
                        x = 16'(v);
                    end
                    default:
                    begin
                        // flat run with rare full-scale spikes
                        x = 16'(v);
                        if ($urandom_range(0, 19) == 0)
                            x = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    end
                endcase
                sender_gap(gap_odds);
                send_sample(x, 1'b0, 17'sd0);
                sent_random++;
                if (sent_random >= RANDOM_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
            end
        end

        // wait for the last results, then a margin for anything stray
        drain();
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
